FILE: sv/rlrw_pkg.sv
`default_nettype none
package rlrw_pkg;

	localparam int SYM_W  = 8;
	localparam int LEN_W  = 16;
	localparam int CNT_W  = 63;
	localparam int PEND_W = 57;
	localparam int RB_W   = 3;
	localparam int KIND_W = 3;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [RB_W-1:0] RUN_BYTES_RST = 3'd4;
	localparam logic [RB_W-1:0] RUN_BYTES_MIN = 3'd2;

	localparam logic [ADDR_W-1:0] ADDR_RUN_BYTES = 3'd0;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_CLOSE  = 1'b1;

	localparam logic [KIND_W-1:0] KIND_DATA = 3'd0;
	localparam logic [KIND_W-1:0] KIND_END  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RECS = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SYMS = 3'd3;
	localparam logic [KIND_W-1:0] KIND_RUNS = 3'd4;

	typedef struct packed {
		logic             mode;
		logic [SYM_W-1:0] symbol;
		logic [LEN_W-1:0] run_length;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SYM_W-1:0]  rec_symbol;
		logic [CNT_W-1:0]  value;
		logic              last;
	} result_t;

	// longest record: 2^(8*n)-1, n clamped to at least two bytes
	function automatic logic [PEND_W-1:0] max_record(input logic [RB_W-1:0] rb);
		logic [RB_W-1:0]   n;
		logic [PEND_W-1:0] m;
		n = (rb < RUN_BYTES_MIN) ? RUN_BYTES_MIN : rb;
		m = '0;
		for (int b = 0; b < PEND_W; b++) begin
			m[b] = (b < int'(n) * 8);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: sv/rlrw_item_if.sv
`default_nettype none
interface rlrw_item_if import rlrw_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/rlrw_result_if.sv
`default_nettype none
interface rlrw_result_if import rlrw_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/rlrw_cfg.sv
`default_nettype none
module rlrw_cfg import rlrw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output logic      [RB_W-1:0]   run_bytes
);

	logic            hit;
	logic [RB_W-1:0] run_bytes_q;

	assign hit    = (paddr == ADDR_RUN_BYTES);
	assign pready = 1'b1;
	assign prdata = hit ? DATA_W'(run_bytes_q) : '0;
	assign run_bytes = run_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bytes_q <= RUN_BYTES_RST;
		end else if (psel && penable && pwrite && hit) begin
			run_bytes_q <= pwdata[RB_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: sv/run_length_record_writer.sv
`default_nettype none
// channel   dir  word                               handshake
// item      in   mode, symbol, run_length           valid/ready
// result    out  kind, rec_symbol, value, last      valid/ready
// apb       in   run_bytes at byte address 0        psel/penable, pready tied high
//
// an append that makes a record loads it from the input register into the result register;
// appends stream at one word per cycle when the result side keeps up
// a close holds the input register until each of its result words has been loaded
// (optional remainder record, end marker, record, symbol and run counts)
// reset clears the stream state and sets run_bytes to four; no clearing pass
// a stalled result register only blocks items that need to write a result
module run_length_record_writer import rlrw_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	rlrw_item_if.sink              item,
	rlrw_result_if.source          result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);

	// footer sequence for a close word
	localparam logic [2:0] PH_FLUSH = 3'd0;
	localparam logic [2:0] PH_END   = 3'd1;
	localparam logic [2:0] PH_RECS  = 3'd2;
	localparam logic [2:0] PH_SYMS  = 3'd3;
	localparam logic [2:0] PH_RUNS  = 3'd4;

	logic [RB_W-1:0] run_bytes;

	rlrw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.run_bytes (run_bytes)
	);

	// input register
	item_t s1_q;
	logic  valid_s1;

	// stream state
	logic [SYM_W-1:0]  cur_q;
	logic              have_q;
	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  rec_cnt_q;
	logic [CNT_W-1:0]  sym_cnt_q;
	logic [CNT_W-1:0]  run_cnt_q;
	logic [2:0]        ph_q;

	logic [SYM_W-1:0]  cur_d;
	logic              have_d;
	logic [PEND_W-1:0] pend_d;
	logic [CNT_W-1:0]  rec_cnt_d;
	logic [CNT_W-1:0]  sym_cnt_d;
	logic [CNT_W-1:0]  run_cnt_d;
	logic [2:0]        ph_d;

	// result register
	result_t res_q;
	logic    res_valid_q;
	result_t res_d;
	logic    load;

	logic              adv;
	logic              in_acc;
	logic              out_free;
	logic [PEND_W-1:0] mx;
	logic              same;
	logic [PEND_W-1:0] sum;
	logic              over;
	logic              has_rem;
	logic [PEND_W-1:0] rem_len;

	assign in_acc     = item.valid && item.ready;
	assign item.ready = !valid_s1 || adv;
	assign out_free   = !res_valid_q || result.ready;

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign mx      = max_record(run_bytes);
	assign same    = have_q && (s1_q.symbol == cur_q);
	assign sum     = pend_q + PEND_W'(s1_q.run_length);
	assign over    = sum > mx;
	assign has_rem = have_q && (pend_q != '0);
	// a remainder above the current limit is cut, the excess dropped
	assign rem_len = (pend_q > mx) ? mx : pend_q;

	always_comb begin
		adv       = 1'b0;
		load      = 1'b0;
		res_d     = '0;
		cur_d     = cur_q;
		have_d    = have_q;
		pend_d    = pend_q;
		rec_cnt_d = rec_cnt_q;
		sym_cnt_d = sym_cnt_q;
		run_cnt_d = run_cnt_q;
		ph_d      = ph_q;
		if (valid_s1) begin
			if (s1_q.mode == MODE_APPEND) begin
				if (same) begin
					if (!over) begin
						// merge into the pending run, nothing goes out
						adv    = 1'b1;
						pend_d = sum;
					end else if (out_free) begin
						// full-length record goes out early
						adv              = 1'b1;
						load             = 1'b1;
						res_d.kind       = KIND_DATA;
						res_d.rec_symbol = cur_q;
						res_d.value      = CNT_W'(mx);
						res_d.last       = 1'b1;
						pend_d           = sum - mx;
						rec_cnt_d        = rec_cnt_q + CNT_W'(1);
						sym_cnt_d        = sym_cnt_q + CNT_W'(mx);
					end
				end else if (!has_rem || out_free) begin
					// symbol change: flush remainder, then start the new run
					adv = 1'b1;
					if (has_rem) begin
						load             = 1'b1;
						res_d.kind       = KIND_DATA;
						res_d.rec_symbol = cur_q;
						res_d.value      = CNT_W'(rem_len);
						res_d.last       = 1'b1;
						rec_cnt_d        = rec_cnt_q + CNT_W'(1);
						sym_cnt_d        = sym_cnt_q + CNT_W'(rem_len);
					end
					cur_d  = s1_q.symbol;
					have_d = 1'b1;
					pend_d = PEND_W'(s1_q.run_length);
					if (s1_q.run_length != '0) begin
						run_cnt_d = run_cnt_q + CNT_W'(1);
					end
				end
			end else if (out_free) begin
				load = 1'b1;
				case (ph_q)
					PH_FLUSH: begin
						if (has_rem) begin
							res_d.kind       = KIND_DATA;
							res_d.rec_symbol = cur_q;
							res_d.value      = CNT_W'(rem_len);
							rec_cnt_d        = rec_cnt_q + CNT_W'(1);
							sym_cnt_d        = sym_cnt_q + CNT_W'(rem_len);
							pend_d           = '0;
							ph_d             = PH_END;
						end else begin
							res_d.kind = KIND_END;
							ph_d       = PH_RECS;
						end
					end
					PH_END: begin
						res_d.kind = KIND_END;
						ph_d       = PH_RECS;
					end
					PH_RECS: begin
						res_d.kind  = KIND_RECS;
						res_d.value = rec_cnt_q;
						ph_d        = PH_SYMS;
					end
					PH_SYMS: begin
						res_d.kind  = KIND_SYMS;
						res_d.value = sym_cnt_q;
						ph_d        = PH_RUNS;
					end
					PH_RUNS: begin
						// final word of the footer: release the close and clear the stream
						res_d.kind  = KIND_RUNS;
						res_d.value = run_cnt_q;
						res_d.last  = 1'b1;
						adv         = 1'b1;
						cur_d       = '0;
						have_d      = 1'b0;
						pend_d      = '0;
						rec_cnt_d   = '0;
						sym_cnt_d   = '0;
						run_cnt_d   = '0;
						ph_d        = PH_FLUSH;
					end
					default: begin
						load = 1'b0;
						ph_d = PH_FLUSH;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			cur_q       <= '0;
			have_q      <= 1'b0;
			pend_q      <= '0;
			rec_cnt_q   <= '0;
			sym_cnt_q   <= '0;
			run_cnt_q   <= '0;
			ph_q        <= PH_FLUSH;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			cur_q     <= cur_d;
			have_q    <= have_d;
			pend_q    <= pend_d;
			rec_cnt_q <= rec_cnt_d;
			sym_cnt_q <= sym_cnt_d;
			run_cnt_q <= run_cnt_d;
			ph_q      <= ph_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_q <= item.data;
		end
		if (load) begin
			res_q <= res_d;
		end
	end

	// no pending length without a buffered symbol
	a_pend_needs_sym: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (pend_q == '0))
		else $error("pending length without a buffered symbol");

	// footer sequence only runs while a close word is held
	a_footer_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_FLUSH) |-> (valid_s1 && (s1_q.mode == MODE_CLOSE)))
		else $error("footer phase without a close word");

	// input side only stalls behind a held word
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> valid_s1)
		else $error("input stalled with an empty input register");

	// a finished close leaves the stream cleared
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (s1_q.mode == MODE_CLOSE)) |=>
			(rec_cnt_q == '0 && sym_cnt_q == '0 && run_cnt_q == '0 && !have_q))
		else $error("stream state not cleared after close");

	// a word is never loaded over one that waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !load)
		else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

FILE: verif/run_length_record_writer_test.sv
`timescale 1ns / 1ps

module run_length_record_writer_test;
	import rlrw_pkg::*;

	logic clk;
	logic arst_n;

	// apb side
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	rlrw_item_if   item_ch ();
	rlrw_result_if result_ch ();

	run_length_record_writer DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// input words waiting to go out, and record words still owed by the block
	item_t   appends_queued[$];
	result_t records_due[$];
	result_t record_batch[$];

	int unsigned words_sent;
	int unsigned words_taken;
	int unsigned mismatches;

	// idling control: quiet turns off all gaps and stalls for a phase
	bit quiet;
	bit word_taken;
	int gap_left;
	int stall_left;

	// shadow of the writer: register copy and stream state
	logic [RB_W-1:0]   rb_shadow;
	logic [SYM_W-1:0]  held_sym;
	logic              sym_held;
	logic [PEND_W-1:0] pend_len;
	logic [CNT_W-1:0]  rec_total;
	logic [CNT_W-1:0]  sym_total;
	logic [CNT_W-1:0]  run_total;

	task automatic report(input string what);
		mismatches++;
		if (mismatches <= 50) begin
			$display("mismatch at %0t: %s", $realtime, what);
		end
	endtask

	// longest record for a run_bytes setting; settings below two bytes act as two
	function automatic logic [PEND_W-1:0] longest_record(input logic [RB_W-1:0] rb);
		logic [PEND_W-1:0] one;
		logic [RB_W-1:0]   nbytes;
		one = PEND_W'(1);
		nbytes = (rb < RUN_BYTES_MIN) ? RUN_BYTES_MIN : rb;
		return (one << (8 * nbytes)) - one;
	endfunction

	task automatic add_word(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
			input logic [CNT_W-1:0] val);
		result_t w;
		w.kind = kind;
		w.rec_symbol = sym;
		w.value = val;
		w.last = 1'b0;
		record_batch.push_back(w);
	endtask

	task automatic emit_data(input logic [CNT_W-1:0] len);
		add_word(KIND_DATA, held_sym, len);
		rec_total = rec_total + 1'b1;
		sym_total = sym_total + len;
	endtask

	// remainder record on a symbol change or close; anything above the
	// current maximum (after run_bytes was lowered) is simply dropped
	task automatic flush_remainder(input logic [PEND_W-1:0] mx);
		if (sym_held && pend_len != 0) begin
			emit_data(CNT_W'((pend_len > mx) ? mx : pend_len));
		end
		pend_len = '0;
	endtask

	// works out the record words caused by one accepted append or close
	task automatic predict_records(input item_t it);
		logic [PEND_W-1:0] mx;
		result_t           w;
		mx = longest_record(rb_shadow);
		record_batch.delete();
		if (it.mode == MODE_CLOSE) begin
			flush_remainder(mx);
			add_word(KIND_END, '0, '0);
			add_word(KIND_RECS, '0, rec_total);
			add_word(KIND_SYMS, '0, sym_total);
			add_word(KIND_RUNS, '0, run_total);
			held_sym = '0;
			sym_held = 1'b0;
			pend_len = '0;
			rec_total = '0;
			sym_total = '0;
			run_total = '0;
		end else if (sym_held && it.symbol == held_sym) begin
			// same symbol: grow the run, at most one full record per word
			pend_len = pend_len + PEND_W'(it.run_length);
			if (pend_len > mx) begin
				emit_data(CNT_W'(mx));
				pend_len = pend_len - mx;
			end
		end else begin
			flush_remainder(mx);
			held_sym = it.symbol;
			sym_held = 1'b1;
			pend_len = PEND_W'(it.run_length);
			if (it.run_length != 0) begin
				run_total = run_total + 1'b1;
			end
		end
		if (record_batch.size() > 0) begin
			w = record_batch.pop_back();
			w.last = 1'b1;
			record_batch.push_back(w);
		end
		foreach (record_batch[i]) begin
			records_due.push_back(record_batch[i]);
		end
	endtask

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 30);
	endfunction

	// item side: note the accepted word at the rising edge
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			predict_records(item_ch.data);
			words_taken++;
			word_taken = 1'b1;
		end
	end

	// item side: present the next word at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || word_taken) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (appends_queued.size() > 0) begin
				item_ch.data <= appends_queued.pop_front();
				item_ch.valid <= 1'b1;
				gap_left = draw_gap();
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result side: random stalls on ready
	always @(negedge clk) begin
		if (quiet) begin
			result_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
			stall_left = draw_gap();
		end
	end

	// result side: compare each accepted word with the oldest one owed
	always @(posedge clk) begin : check_records
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (records_due.size() == 0) begin
				report($sformatf("unexpected word kind %0d value %0d", got.kind, got.value));
			end else begin
				want = records_due.pop_front();
				if (got.kind !== want.kind) begin
					report($sformatf("kind %0d, want %0d", got.kind, want.kind));
				end
				if (got.rec_symbol !== want.rec_symbol) begin
					report($sformatf("rec_symbol %0d, want %0d", got.rec_symbol,
						want.rec_symbol));
				end
				if (got.value !== want.value) begin
					report($sformatf("value %0d, want %0d (kind %0d)", got.value,
						want.value, want.kind));
				end
				if (got.last !== want.last) begin
					report($sformatf("last %0b, want %0b (kind %0d)", got.last,
						want.last, want.kind));
				end
			end
		end
	end

	task automatic queue_word(input logic mode, input logic [SYM_W-1:0] sym,
			input logic [LEN_W-1:0] len);
		item_t it;
		it.mode = mode;
		it.symbol = sym;
		it.run_length = len;
		appends_queued.push_back(it);
		words_sent++;
	endtask

	// one apb transfer: setup, access, then release; a read checks the register
	task automatic apb_access(input logic wr, input logic [DATA_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_RUN_BYTES;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (wr) begin
			rb_shadow = val[RB_W-1:0];
		end else if (prdata[RB_W-1:0] !== rb_shadow) begin
			report($sformatf("run_bytes reads %0d, want %0d", prdata[RB_W-1:0], rb_shadow));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_run_bytes(input int unsigned rb);
		apb_access(1'b1, DATA_W'(rb));
		apb_access(1'b0, '0);
	endtask

	// wait until every word is taken and every record word has arrived, then
	// give a word with no result time to leave the block
	task automatic settle_stream();
		while (words_taken != words_sent || records_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1, 2: begin
				return '1;
			end
			3: begin
				return LEN_W'($urandom_range(65000, 65535));
			end
			4: begin
				return LEN_W'($urandom_range(1, 15));
			end
			default: begin
				return LEN_W'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	// mostly runs of several appends of one symbol, a few lone appends and closes;
	// a small symbol pool makes neighbouring runs share a symbol now and then
	task automatic random_burst(input int n);
		int               made;
		int               r;
		int               appends;
		logic [SYM_W-1:0] s;
		made = 0;
		while (made < n) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				queue_word(MODE_CLOSE, SYM_W'($urandom_range(0, 255)),
					LEN_W'($urandom_range(0, 65535)));
				made++;
			end else if (r < 15) begin
				queue_word(MODE_APPEND, SYM_W'($urandom_range(0, 255)), pick_length());
				made++;
			end else begin
				s = (r < 60) ? SYM_W'($urandom_range(0, 3)) : SYM_W'($urandom_range(0, 255));
				appends = $urandom_range(1, 8);
				repeat (appends) begin
					queue_word(MODE_APPEND, s, pick_length());
					made++;
				end
			end
		end
	endtask

	int unsigned settings[10] = '{0, 7, 1, 2, 5, 2, 3, 6, 2, 4};

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;
		quiet = 1'b0;
		word_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		words_sent = 0;
		words_taken = 0;
		mismatches = 0;
		rb_shadow = RUN_BYTES_RST;
		held_sym = '0;
		sym_held = 1'b0;
		pend_len = '0;
		rec_total = '0;
		sym_total = '0;
		run_total = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of run_bytes
		apb_access(1'b0, '0);

		// close on an empty stream: footer only, all counts zero
		queue_word(MODE_CLOSE, '0, '0);
		// zero-length first run, then growth of the same symbol
		queue_word(MODE_APPEND, 8'h00, 16'd0);
		queue_word(MODE_APPEND, 8'h00, 16'd5);
		// symbol change flushes the remainder
		queue_word(MODE_APPEND, 8'hFF, 16'hFFFF);
		queue_word(MODE_APPEND, 8'hFF, 16'd0);
		queue_word(MODE_APPEND, 8'hA5, 16'd1);
		// close with junk in the ignored fields
		queue_word(MODE_CLOSE, 8'h5A, 16'hA5A5);
		settle_stream();

		// two-byte records: full records leave as soon as the sum passes the maximum
		set_run_bytes(2);
		queue_word(MODE_APPEND, 8'h5A, 16'hFFFF);
		queue_word(MODE_APPEND, 8'h5A, 16'd1);
		queue_word(MODE_APPEND, 8'h5A, 16'hFFFF);
		queue_word(MODE_APPEND, 8'h5A, 16'd0);
		// new symbol with zero length: no run counted, and nothing to flush after
		queue_word(MODE_APPEND, 8'h01, 16'd0);
		queue_word(MODE_APPEND, 8'h02, 16'd3);
		queue_word(MODE_CLOSE, '0, '0);
		settle_stream();

		// build a long run at three bytes, then lower run_bytes under it
		set_run_bytes(3);
		repeat (4) queue_word(MODE_APPEND, 8'h07, 16'hFFFF);
		settle_stream();
		set_run_bytes(2);
		queue_word(MODE_APPEND, 8'h07, 16'd0);
		queue_word(MODE_APPEND, 8'h07, 16'd0);
		// flush clips the remainder to the maximum and drops the rest
		queue_word(MODE_APPEND, 8'h08, 16'd2);
		queue_word(MODE_CLOSE, '0, '0);
		settle_stream();

		// random phases across settings, extremes and out-of-range values included
		foreach (settings[i]) begin
			set_run_bytes(settings[i]);
			quiet = ($urandom_range(0, 3) == 0);
			random_burst(50);
			settle_stream();
		end
		quiet = 1'b0;
		queue_word(MODE_CLOSE, '0, '0);
		settle_stream();
		repeat (10) @(negedge clk);

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
